// File: sv/bbad_pkg.sv
package bbad_pkg;

   localparam int DEF_MAX_DIMS = 16;
   localparam int COORD_W      = 24;
   localparam int GAP_W        = COORD_W + 1;
   localparam int SQ_W         = 2 * GAP_W;
   localparam int DIST_W       = 52;
   localparam int IDX_W        = 4;
   localparam int DIMS_W       = 5;
   localparam int CNT_W        = 8;
   localparam int ACT_W        = 3;
   localparam int REQ_DATA_W   = 56;
   localparam int REQ_USER_W   = 4;
   localparam int RSP_DATA_W   = 104;
   localparam int RSP_USER_W   = 2;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 5'd2;
   localparam logic [DIST_W-1:0] DIST_MAX   = '1;

   localparam logic [ACT_W-1:0] ACT_ADD_POINT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD_BOX   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MULT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic gap_en;
      logic sq_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// File: sv/bbad_ctrl.sv
module bbad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bbad_pkg::sts_type sts,
   output bbad_pkg::cmd_type cmd
);
   import bbad_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.gap_en = 1'b1;
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            cmd.sq_en = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/bbad_dp.sv
module bbad_dp #(
   parameter int MAX_DIMS = bbad_pkg::DEF_MAX_DIMS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bbad_pkg::cmd_type                   cmd,
   output bbad_pkg::sts_type                   sts,
   input  logic [bbad_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [bbad_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bbad_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic [bbad_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_valid,
   input  logic [bbad_pkg::DIMS_W-1:0]         csr_data
);
   import bbad_pkg::*;

   localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIMS);

   logic [DIMS_W-1:0]         dims_ff;
   logic [ACT_W-1:0]          act_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [COORD_W-1:0] vlo_ff;
   logic signed [COORD_W-1:0] vhi_ff;
   logic                      oe_ff;

   logic [COORD_W-1:0]        low_mem  [MAX_DIMS];
   logic [COORD_W-1:0]        high_mem [MAX_DIMS];
   logic [MAX_DIMS-1:0]       vld_ff;
   logic [MAX_DIMS-1:0]       vld_in;
   logic [COORD_W-1:0]        lo_rd_ff;
   logic [COORD_W-1:0]        hi_rd_ff;
   logic                      vld_rd_ff;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;

   logic signed [COORD_W-1:0] lo_cur;
   logic signed [COORD_W-1:0] hi_cur;
   logic signed [GAP_W-1:0]   d1;
   logic signed [GAP_W-1:0]   d2;
   logic [GAP_W-1:0]          g1;
   logic [GAP_W-1:0]          g2;
   logic [GAP_W-1:0]          gap_ff;
   logic                      inside_ff;
   logic [SQ_W-1:0]           sq_ff;

   logic                      holds_ff;
   logic                      holds_in;
   logic [DIST_W-1:0]         acc_ff;
   logic [DIST_W-1:0]         acc_in;

   logic [CNT_W-1:0]          dims_x;
   logic [CNT_W-1:0]          nd;
   logic [CNT_W-1:0]          idx_x;
   logic                      err;
   logic                      last;
   logic                      is_clear;
   logic                      is_add;
   logic                      is_query;
   logic signed [COORD_W-1:0] new_hi;
   logic signed [COORD_W-1:0] wr_lo;
   logic signed [COORD_W-1:0] wr_hi;
   logic [DIST_W-1:0]         base;
   logic [DIST_W:0]           sum_raw;
   logic [DIST_W-1:0]         sum;
   logic [DIST_W-1:0]         dist_out;
   logic [COORD_W-1:0]        low_out;
   logic [COORD_W-1:0]        high_out;
   logic                      last_out;
   logic                      err_out;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic                      rsp_last_ff;
   logic [RSP_USER_W-1:0]     rsp_user_ff;

   assign rd_addr = AW'(req_tdata[IDX_W-1:0]);
   assign wr_addr = AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
      end else if (csr_valid) begin
         dims_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_tuser[ACT_W-1:0];
         oe_ff  <= req_tuser[ACT_W];
         idx_ff <= req_tdata[IDX_W-1:0];
         vlo_ff <= req_tdata[IDX_W +: COORD_W];
         vhi_ff <= req_tdata[IDX_W+COORD_W +: COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_add) begin
         low_mem[wr_addr]  <= wr_lo;
         high_mem[wr_addr] <= wr_hi;
      end
      if (cmd.load) begin
         lo_rd_ff  <= low_mem[rd_addr];
         hi_rd_ff  <= high_mem[rd_addr];
         vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.commit) begin
         if (is_clear) begin
            vld_in = '0;
         end else if (is_add) begin
            vld_in[wr_addr] = 1'b1;
         end
      end
   end

   assign lo_cur = vld_rd_ff ? lo_rd_ff : '0;
   assign hi_cur = vld_rd_ff ? hi_rd_ff : '0;

   assign d1 = GAP_W'(lo_cur) - GAP_W'(vlo_ff);
   assign d2 = GAP_W'(hi_cur) - GAP_W'(vlo_ff);
   assign g1 = d1[GAP_W-1] ? GAP_W'(-d1) : GAP_W'(d1);
   assign g2 = d2[GAP_W-1] ? GAP_W'(-d2) : GAP_W'(d2);

   always_ff @(posedge clock) begin
      if (cmd.gap_en) begin
         inside_ff <= (lo_cur <= vlo_ff) && (vlo_ff <= hi_cur);
         gap_ff    <= (g1 < g2) ? g1 : g2;
      end
      if (cmd.sq_en) begin
         sq_ff <= gap_ff * gap_ff;
      end
   end

   always_comb begin
      dims_x   = CNT_W'(dims_ff);
      if (dims_x == '0) begin
         nd = CNT_W'(1);
      end else if (dims_x > MAX_CNT) begin
         nd = MAX_CNT;
      end else begin
         nd = dims_x;
      end
      idx_x    = CNT_W'(idx_ff);
      err      = idx_x >= nd;
      last     = idx_x == (nd - CNT_W'(1));
      is_clear = act_ff == ACT_CLEAR;
      is_add   = !err && ((act_ff == ACT_ADD_POINT) || ((act_ff == ACT_ADD_BOX) && !oe_ff));
      is_query = !err && (act_ff == ACT_QUERY);
      new_hi   = (act_ff == ACT_ADD_POINT) ? vlo_ff : vhi_ff;
      if (holds_ff) begin
         wr_lo = (vlo_ff < lo_cur) ? vlo_ff : lo_cur;
         wr_hi = (new_hi > hi_cur) ? new_hi : hi_cur;
      end else begin
         wr_lo = vlo_ff;
         wr_hi = new_hi;
      end
      base    = (idx_ff == '0) ? '0 : acc_ff;
      sum_raw = {1'b0, base} + (inside_ff ? '0 : (DIST_W+1)'(sq_ff));
      sum     = sum_raw[DIST_W] ? DIST_MAX : sum_raw[DIST_W-1:0];

      holds_in = holds_ff;
      acc_in   = acc_ff;
      if (is_clear) begin
         holds_in = 1'b0;
         acc_in   = '0;
      end else if (is_add && !holds_ff && last) begin
         holds_in = 1'b1;
      end else if (is_query) begin
         acc_in = (!holds_ff || last) ? '0 : sum;
      end

      dist_out = '0;
      if (!is_clear && is_query) begin
         dist_out = holds_ff ? sum : DIST_MAX;
      end
      if (is_clear || err) begin
         low_out  = '0;
         high_out = '0;
      end else if (is_add) begin
         low_out  = wr_lo;
         high_out = wr_hi;
      end else begin
         low_out  = lo_cur;
         high_out = hi_cur;
      end
      last_out = is_clear ? last : (!err && last);
      err_out  = !is_clear && err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         holds_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         vld_ff <= vld_in;
         if (cmd.commit) begin
            holds_ff <= holds_in;
            acc_ff   <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= RSP_DATA_W'({high_out, low_out, dist_out});
         rsp_last_ff <= last_out;
         rsp_user_ff <= {err_out, !holds_in};
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser    = rsp_user_ff;

endmodule

// File: sv/bounding_box_accumulate_and_distance_unit.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: dim_index, value_low, value_high
//                                            tuser: action, other_empty
// rsp      out        rsp_tvalid/rsp_tready  tdata: distance_sq, low_bound, high_bound
//                                            tlast: last_dim; tuser: box_empty, error
// csr      in         csr_valid/csr_ready    dims
//
// Each item passes through bound fetch, face gap, 25x25 square, then accumulate and commit.
// The next item is accepted while a finished result waits in the output register.
// A result not taken holds the commit step until rsp_tready frees the output register.
// Reset clears the per-dimension valid bits directly; there is no clearing pass.
module bounding_box_accumulate_and_distance_unit #(
   parameter int MAX_DIMS = bbad_pkg::DEF_MAX_DIMS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // dim_index[3:0], value_low[27:4], value_high[51:28], zero fill[55:52]
   input  logic [bbad_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action[2:0], other_empty[3]
   input  logic [bbad_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // distance_sq[51:0], low_bound[75:52], high_bound[99:76], zero fill[103:100]
   output logic [bbad_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // box_empty[0], error[1]
   output logic [bbad_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bbad_pkg::DIMS_W-1:0]      csr_data
);
   import bbad_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   bbad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbad_dp #(
      .MAX_DIMS (MAX_DIMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data)
   );

endmodule

// File: sv/bbad_checker.sv
module bbad_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bbad_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast,
   input logic [bbad_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import bbad_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while an item is in progress");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata[DIST_W-1:0] == '0) && !rsp_tlast)
      else $error("error item carries distance or last flag");

   a_empty_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[DIST_W-1:0] == '0) || (rsp_tdata[DIST_W-1:0] == DIST_MAX))
      else $error("empty box reports a partial distance");

endmodule

bind bounding_box_accumulate_and_distance_unit bbad_checker u_bbad_checker (.*);

// File: test/tb_bounding_box_accumulate_and_distance_unit.sv
`timescale 1ns / 1ps

module tb_bounding_box_accumulate_and_distance_unit;
   import bbad_pkg::*;

   localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
   localparam int PHASE_ITEMS = 92;
   localparam int NUM_PHASES  = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [ACT_W-1:0]          action;
      logic [IDX_W-1:0]          dim_index;
      logic signed [COORD_W-1:0] value_low;
      logic signed [COORD_W-1:0] value_high;
      logic                      other_empty;
   } box_req_t;

   typedef struct packed {
      logic [DIST_W-1:0]         distance_sq;
      logic                      last_dim;
      logic                      box_empty;
      logic signed [COORD_W-1:0] low_bound;
      logic signed [COORD_W-1:0] high_bound;
      logic                      error;
   } box_rsp_t;

   typedef struct packed {
      logic     has_rsp;
      box_req_t req;
      box_rsp_t rsp;
   } step_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [REQ_USER_W-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [DIMS_W-1:0]       csr_data = '0;

   logic signed [COORD_W-1:0] bound_lo [DEF_MAX_DIMS] = '{default: '0};
   logic signed [COORD_W-1:0] bound_hi [DEF_MAX_DIMS] = '{default: '0};
   logic                      box_filled = 1'b0;
   logic [DIST_W-1:0]         dist_acc = '0;
   logic [DIMS_W-1:0]         dims_cfg = DIMS_RESET;

   box_rsp_t  pending_results [$];
   step_row_t dir_rows [$];
   int        mismatch_count = 0;
   int        tx_idle_pct = 12;
   int        rx_idle_pct = 64;
   int        stall_cycles = 0;

   bounding_box_accumulate_and_distance_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic int active_dims();
      if (dims_cfg == 0) return 1;
      if (dims_cfg > DEF_MAX_DIMS) return DEF_MAX_DIMS;
      return int'(dims_cfg);
   endfunction

   function automatic box_rsp_t predict_box_result(box_req_t r);
      box_rsp_t                  res;
      int                        nd;
      int                        idx;
      logic                      is_last;
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hi;
      logic signed [COORD_W:0]   l;
      logic signed [COORD_W:0]   h;
      logic signed [COORD_W:0]   v;
      logic [COORD_W:0]          gap_l;
      logic [COORD_W:0]          gap_h;
      logic [COORD_W:0]          gap;
      logic [2*COORD_W+1:0]      sq;
      logic [DIST_W:0]           sum;
      res = '0;
      nd = active_dims();
      idx = int'(r.dim_index);
      if (r.action == ACT_CLEAR) begin
         foreach (bound_lo[i]) begin
            bound_lo[i] = '0;
            bound_hi[i] = '0;
         end
         box_filled = 1'b0;
         dist_acc = '0;
         res.last_dim = (idx == nd - 1);
         res.box_empty = 1'b1;
         return res;
      end
      if (idx >= nd) begin
         res.box_empty = !box_filled;
         res.error = 1'b1;
         return res;
      end
      is_last = (idx == nd - 1);
      if (r.action == ACT_ADD_POINT || (r.action == ACT_ADD_BOX && !r.other_empty)) begin
         lo = r.value_low;
         hi = (r.action == ACT_ADD_POINT) ? r.value_low : r.value_high;
         if (!box_filled) begin
            bound_lo[idx] = lo;
            bound_hi[idx] = hi;
            if (is_last) box_filled = 1'b1;
         end else begin
            if (lo < bound_lo[idx]) bound_lo[idx] = lo;
            if (hi > bound_hi[idx]) bound_hi[idx] = hi;
         end
      end else if (r.action == ACT_QUERY) begin
         if (!box_filled) begin
            res.distance_sq = DIST_MAX;
            dist_acc = '0;
         end else begin
            l = bound_lo[idx];
            h = bound_hi[idx];
            v = r.value_low;
            sum = (idx == 0) ? '0 : {1'b0, dist_acc};
            if (!(l <= v && v <= h)) begin
               gap_l = (l > v) ? l - v : v - l;
               gap_h = (h > v) ? h - v : v - h;
               gap = (gap_l < gap_h) ? gap_l : gap_h;
               sq = gap * gap;
               sum = sum + sq;
               if (sum > {1'b0, DIST_MAX}) sum = {1'b0, DIST_MAX};
            end
            res.distance_sq = sum[DIST_W-1:0];
            dist_acc = is_last ? '0 : sum[DIST_W-1:0];
         end
      end
      res.last_dim = is_last;
      res.box_empty = !box_filled;
      res.low_bound = bound_lo[idx];
      res.high_bound = bound_hi[idx];
      return res;
   endfunction

   function automatic box_req_t make_req(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                         logic signed [COORD_W-1:0] lo,
                                         logic signed [COORD_W-1:0] hi, logic oe);
      box_req_t r;
      r.action = act;
      r.dim_index = idx;
      r.value_low = lo;
      r.value_high = hi;
      r.other_empty = oe;
      return r;
   endfunction

   function automatic step_row_t rule_step(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                           logic signed [COORD_W-1:0] lo,
                                           logic signed [COORD_W-1:0] hi, logic oe);
      step_row_t s;
      s.has_rsp = 1'b0;
      s.req = make_req(act, idx, lo, hi, oe);
      s.rsp = '0;
      return s;
   endfunction

   function automatic step_row_t known_step(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                            logic signed [COORD_W-1:0] lo,
                                            logic signed [COORD_W-1:0] hi, logic oe,
                                            logic [DIST_W-1:0] dist_sq, logic last_dim,
                                            logic empty, logic signed [COORD_W-1:0] lb,
                                            logic signed [COORD_W-1:0] hb, logic err);
      step_row_t s;
      s.has_rsp = 1'b1;
      s.req = make_req(act, idx, lo, hi, oe);
      s.rsp.distance_sq = dist_sq;
      s.rsp.last_dim = last_dim;
      s.rsp.box_empty = empty;
      s.rsp.low_bound = lb;
      s.rsp.high_bound = hb;
      s.rsp.error = err;
      return s;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return COORD_MIN;
      if (pick == 1) return COORD_MAX;
      if (pick < 6) return COORD_W'(int'($urandom_range(16383)) - 8192);
      return COORD_W'($urandom);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 200)
         $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_item(input box_req_t r, input logic has_rsp = 1'b0,
                            input box_rsp_t fixed_rsp = '0);
      box_rsp_t want;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, r.value_high, r.value_low, r.dim_index};
      req_tuser <= {r.other_empty, r.action};
      do @(posedge clock); while (!req_tready);
      want = predict_box_result(r);
      pending_results.push_back(has_rsp ? fixed_rsp : want);
      @(negedge clock);
   endtask

   task automatic write_dims(input logic [DIMS_W-1:0] value);
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      dims_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : check_rsp
      box_rsp_t got;
      box_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.distance_sq = rsp_tdata[51:0];
         got.low_bound = rsp_tdata[75:52];
         got.high_bound = rsp_tdata[99:76];
         got.last_dim = rsp_tlast;
         got.box_empty = rsp_tuser[0];
         got.error = rsp_tuser[1];
         if (pending_results.size() == 0) begin
            report_mismatch("item with none pending", got.distance_sq, '0);
         end else begin
            want = pending_results.pop_front();
            if (got.distance_sq !== want.distance_sq)
               report_mismatch("distance_sq", got.distance_sq, want.distance_sq);
            if (got.last_dim !== want.last_dim)
               report_mismatch("last_dim", got.last_dim, want.last_dim);
            if (got.box_empty !== want.box_empty)
               report_mismatch("box_empty", got.box_empty, want.box_empty);
            if (got.low_bound !== want.low_bound)
               report_mismatch("low_bound", got.low_bound, want.low_bound);
            if (got.high_bound !== want.high_bound)
               report_mismatch("high_bound", got.high_bound, want.high_bound);
            if (got.error !== want.error)
               report_mismatch("error", got.error, want.error);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [DIMS_W-1:0]         dims_plan [NUM_PHASES];
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hi;
      logic signed [COORD_W-1:0] tmp;
      box_req_t                  r;
      int                        nd;
      int                        pick;
      int                        count;

      dims_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd1, 5'd8,
                    5'd5, 5'd16, 5'd2, 5'd12};

      dir_rows.push_back(known_step(ACT_READ, 4'd0, '0, '0, 1'b0,
                                    '0, 1'b0, 1'b1, '0, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_QUERY, 4'd0, '0, '0, 1'b0,
                                    DIST_MAX, 1'b0, 1'b1, '0, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_ADD_POINT, 4'd2, 24'sd5, '0, 1'b0,
                                    '0, 1'b0, 1'b1, '0, '0, 1'b1));
      dir_rows.push_back(known_step(ACT_ADD_BOX, 4'd0, 24'sd7, 24'sd9, 1'b1,
                                    '0, 1'b0, 1'b1, '0, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_ADD_POINT, 4'd0, COORD_MAX, '0, 1'b0,
                                    '0, 1'b0, 1'b1, COORD_MAX, COORD_MAX, 1'b0));
      dir_rows.push_back(known_step(ACT_ADD_POINT, 4'd1, COORD_MIN, '0, 1'b0,
                                    '0, 1'b1, 1'b0, COORD_MIN, COORD_MIN, 1'b0));
      dir_rows.push_back(known_step(ACT_ADD_POINT, 4'd0, COORD_MIN, '0, 1'b0,
                                    '0, 1'b0, 1'b0, COORD_MIN, COORD_MAX, 1'b0));
      dir_rows.push_back(known_step(ACT_QUERY, 4'd0, '0, '0, 1'b0,
                                    '0, 1'b0, 1'b0, COORD_MIN, COORD_MAX, 1'b0));
      dir_rows.push_back(rule_step(ACT_QUERY, 4'd1, COORD_MAX, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_QUERY, 4'd15, '0, '0, 1'b0,
                                    '0, 1'b0, 1'b0, '0, '0, 1'b1));
      dir_rows.push_back(rule_step(ACT_ADD_BOX, 4'd1, 24'sd5, -24'sd5, 1'b0));
      dir_rows.push_back(rule_step(ACT_SPARE_5, 4'd1, 24'sd3, 24'sd3, 1'b0));
      dir_rows.push_back(rule_step(ACT_SPARE_6, 4'd0, COORD_MIN, COORD_MAX, 1'b1));
      dir_rows.push_back(rule_step(ACT_SPARE_7, 4'd1, COORD_MAX, COORD_MIN, 1'b0));
      dir_rows.push_back(rule_step(ACT_QUERY, 4'd1, '0, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_CLEAR, 4'd15, COORD_MAX, COORD_MAX, 1'b1,
                                    '0, 1'b0, 1'b1, '0, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_QUERY, 4'd1, 24'sd1, '0, 1'b0,
                                    DIST_MAX, 1'b1, 1'b1, '0, '0, 1'b0));
      dir_rows.push_back(rule_step(ACT_ADD_BOX, 4'd0, 24'sd100, -24'sd100, 1'b0));
      dir_rows.push_back(rule_step(ACT_ADD_BOX, 4'd1, COORD_MIN, COORD_MAX, 1'b0));
      dir_rows.push_back(rule_step(ACT_QUERY, 4'd0, '0, '0, 1'b0));
      dir_rows.push_back(rule_step(ACT_QUERY, 4'd1, COORD_MIN, '0, 1'b0));
      dir_rows.push_back(rule_step(ACT_ADD_POINT, 4'd0, COORD_MAX, COORD_MIN, 1'b0));
      dir_rows.push_back(rule_step(ACT_READ, 4'd0, '0, '0, 1'b0));
      dir_rows.push_back(known_step(ACT_CLEAR, 4'd1, '0, '0, 1'b0,
                                    '0, 1'b1, 1'b1, '0, '0, 1'b0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].has_rsp, dir_rows[i].rsp);
      req_tvalid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         tx_idle_pct = (p < 4) ? 12 : (p < 8) ? 64 : 0;
         rx_idle_pct = (p < 4) ? 64 : (p < 8) ? 12 : 0;
         write_dims(dims_plan[p]);
         count = 0;
         while (count < PHASE_ITEMS) begin
            nd = active_dims();
            pick = $urandom_range(99);
            if (pick < 25) begin
               for (int d = 0; d < nd; d++)
                  send_item(make_req(ACT_ADD_POINT, IDX_W'(d), rand_coord(), rand_coord(),
                                     1'($urandom_range(1))));
               count += nd;
            end else if (pick < 40) begin
               for (int d = 0; d < nd; d++) begin
                  lo = rand_coord();
                  hi = rand_coord();
                  if (lo > hi && $urandom_range(5) != 0) begin
                     tmp = lo;
                     lo = hi;
                     hi = tmp;
                  end
                  send_item(make_req(ACT_ADD_BOX, IDX_W'(d), lo, hi,
                                     $urandom_range(7) == 0));
               end
               count += nd;
            end else if (pick < 70) begin
               for (int d = 0; d < nd; d++)
                  send_item(make_req(ACT_QUERY, IDX_W'(d), rand_coord(), rand_coord(),
                                     1'($urandom_range(1))));
               count += nd;
            end else if (pick < 78) begin
               for (int d = 0; d < nd; d++)
                  send_item(make_req(ACT_READ, IDX_W'(d), rand_coord(), rand_coord(),
                                     1'($urandom_range(1))));
               count += nd;
            end else if (pick < 83) begin
               send_item(make_req(ACT_CLEAR, IDX_W'($urandom_range(15)), rand_coord(),
                                  rand_coord(), 1'($urandom_range(1))));
               count++;
            end else begin
               r = make_req(ACT_W'($urandom_range(7)), IDX_W'($urandom_range(15)),
                            COORD_W'($urandom), COORD_W'($urandom),
                            1'($urandom_range(1)));
               send_item(r);
               if (r.action == ACT_CLEAR || r.dim_index < nd) count++;
            end
         end
         req_tvalid <= 1'b0;
      end

      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
sv/bbad_pkg.sv
sv/bbad_ctrl.sv
sv/bbad_dp.sv
sv/bounding_box_accumulate_and_distance_unit.sv
sv/bbad_checker.sv
test/tb_bounding_box_accumulate_and_distance_unit.sv
